// ----- sv/m3inv_pkg.sv -----
`default_nettype none

package m3inv_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int N_ENT = 9;

    // Each adjugate entry, in row-major order of the inverse, is
    // m[a]*m[b] - m[c]*m[d] with the indexes {a, b, c, d} below.
    localparam int COF_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

`default_nettype wire

// ----- sv/matrix3x3_inverse.sv -----
`default_nettype none

// Channel  Dir  Bus              Contents
// s_*      in   s_tdata          nine signed entries, row-major
// m_*      out  m_tdata, tuser   nine inverse entries, determinant; singular flag
//
// A new word can be accepted every cycle while the pipe has room. The
// quotient takes one restoring step per quotient bit, one pipeline stage
// each. Reset clears only the stage valid bits. A stalled output holds
// its stage; upstream stages keep filling empty slots until the pipe is
// full.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = m3inv_pkg::DEF_WORD_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3, in_r3c1, in_r3c2, in_r3c3
    input  logic [((9*WORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // inv_r1c1 .. inv_r3c3 (row-major), det_value
    output logic [((10*WORD_BITS+7)/8)*8-1:0] m_tdata,
    // singular
    output logic [0:0] m_tuser
);
    import m3inv_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int CW   = 2*W + 1;
    localparam int DTW  = 3*W + 1;
    localparam int RW   = (2*F > 2*W - 1) ? (2*W + 2*F + 1) : 4*W;
    localparam int DS   = 7;
    localparam int NS   = W + 8;
    localparam int OTW  = ((10*W+7)/8)*8;
    localparam logic [DTW-1:0] RND = (DTW'(1) << (2*F)) - DTW'(1);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // Stage 0: input matrix.
    logic signed [W-1:0] m_reg [N_ENT];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                m_reg[i] <= $signed(s_tdata[i*W +: W]);
            end
        end
    end

    // Stage 1: the eighteen 2x2 minor products.
    logic signed [2*W-1:0] p_reg [2*N_ENT];
    logic signed [W-1:0]   mt1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < N_ENT; j++)
            begin
                p_reg[2*j]   <= m_reg[COF_IDX[j][0]] * m_reg[COF_IDX[j][1]];
                p_reg[2*j+1] <= m_reg[COF_IDX[j][2]] * m_reg[COF_IDX[j][3]];
            end
            for (int t = 0; t < 3; t++)
            begin
                mt1_reg[t] <= m_reg[t];
            end
        end
    end

    // Stage 2: adjugate cofactors.
    logic signed [CW-1:0] cof2_reg [N_ENT];
    logic signed [W-1:0]  mt2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < N_ENT; j++)
            begin
                cof2_reg[j] <= CW'(p_reg[2*j]) - CW'(p_reg[2*j+1]);
            end
            mt2_reg <= mt1_reg;
        end
    end

    // Stage 3: first-row entry times cofactor, split into two narrow products.
    logic signed [CW-1:0] ph_reg [3];
    logic signed [CW-1:0] pl_reg [3];
    logic signed [CW-1:0] cof3_reg [N_ENT];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int t = 0; t < 3; t++)
            begin
                ph_reg[t] <= mt2_reg[t] * $signed(cof2_reg[3*t][CW-1:W]);
                pl_reg[t] <= mt2_reg[t] * $signed({1'b0, cof2_reg[3*t][W-1:0]});
            end
            cof3_reg <= cof2_reg;
        end
    end

    // Stage 4: recombine the partial products.
    logic signed [DTW-1:0] term_reg [3];
    logic signed [CW-1:0]  cof4_reg [N_ENT];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int t = 0; t < 3; t++)
            begin
                term_reg[t] <= (DTW'(ph_reg[t]) <<< W) + DTW'(pl_reg[t]);
            end
            cof4_reg <= cof3_reg;
        end
    end

    // Stage 5: determinant.
    logic signed [DTW-1:0] det_reg;
    logic signed [CW-1:0]  cof5_reg [N_ENT];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            cof5_reg <= cof4_reg;
        end
    end

    // Stage 6: magnitudes, signs and the determinant output.
    logic                  det_neg;
    logic [DTW-1:0]        det_abs;
    logic signed [DTW-1:0] det_sh;
    logic [W-1:0]          detv_next;

    always_comb
    begin
        det_neg = det_reg[DTW-1];
        det_abs = det_neg ? (~det_reg + DTW'(1)) : det_reg;
        det_sh  = det_neg ? ((det_reg + $signed(RND)) >>> (2*F)) : (det_reg >>> (2*F));
        if (det_sh[DTW-1:W-1] == {(DTW-W+1){det_sh[DTW-1]}})
        begin
            detv_next = det_sh[W-1:0];
        end
        else
        begin
            detv_next = det_sh[DTW-1] ? WMIN : WMAX;
        end
    end

    logic [RW-1:0] r6_reg [N_ENT];
    logic          neg6_reg [N_ENT];
    logic [RW-1:0] dmag6_reg;
    logic          zero6_reg;
    logic [W-1:0]  detv6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int j = 0; j < N_ENT; j++)
            begin
                r6_reg[j] <= RW'(cof5_reg[j][CW-1] ? (~cof5_reg[j] + CW'(1))
                                                   : cof5_reg[j]) << (2*F);
                neg6_reg[j] <= cof5_reg[j][CW-1] ^ det_neg;
            end
            dmag6_reg <= RW'(det_abs);
            zero6_reg <= (det_reg == '0);
            detv6_reg <= detv_next;
        end
    end

    // Stages 7 .. 7+W-1: one restoring step per quotient bit, MSB first.
    // A set top bit means the quotient does not fit and the entry saturates.
    logic [RW-1:0] dr_reg [W][N_ENT];
    logic [W-1:0]  dq_reg [W][N_ENT];
    logic          dn_reg [W][N_ENT];
    logic [RW-1:0] dd_reg [W];
    logic          dz_reg [W];
    logic [W-1:0]  dv_reg [W];

    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [RW-1:0] r_in [N_ENT];
        logic [W-1:0]  q_in [N_ENT];
        logic          n_in [N_ENT];
        logic [RW-1:0] d_in;
        logic          z_in;
        logic [W-1:0]  v_in;
        logic [RW-1:0] dsh;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int j = 0; j < N_ENT; j++)
                begin
                    r_in[j] = r6_reg[j];
                    q_in[j] = '0;
                    n_in[j] = neg6_reg[j];
                end
                d_in = dmag6_reg;
                z_in = zero6_reg;
                v_in = detv6_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int j = 0; j < N_ENT; j++)
                begin
                    r_in[j] = dr_reg[k-1][j];
                    q_in[j] = dq_reg[k-1][j];
                    n_in[j] = dn_reg[k-1][j];
                end
                d_in = dd_reg[k-1];
                z_in = dz_reg[k-1];
                v_in = dv_reg[k-1];
            end
        end

        assign dsh = d_in << (W - 1 - k);

        always_ff @(posedge clk)
        begin
            if (en[DS + k])
            begin
                for (int j = 0; j < N_ENT; j++)
                begin
                    if (r_in[j] >= dsh)
                    begin
                        dr_reg[k][j] <= r_in[j] - dsh;
                        dq_reg[k][j] <= q_in[j] | (W'(1) << (W - 1 - k));
                    end
                    else
                    begin
                        dr_reg[k][j] <= r_in[j];
                        dq_reg[k][j] <= q_in[j];
                    end
                    dn_reg[k][j] <= n_in[j];
                end
                dd_reg[k] <= d_in;
                dz_reg[k] <= z_in;
                dv_reg[k] <= v_in;
            end
        end
    end

    // Output stage: sign, saturation and the singular case.
    logic [W-1:0] out_reg [N_ENT];
    logic [W-1:0] det_out_reg;
    logic         sing_reg;

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            for (int j = 0; j < N_ENT; j++)
            begin
                if (dz_reg[W-1])
                begin
                    out_reg[j] <= '0;
                end
                else if (dq_reg[W-1][j][W-1])
                begin
                    out_reg[j] <= dn_reg[W-1][j] ? WMIN : WMAX;
                end
                else if (dn_reg[W-1][j])
                begin
                    out_reg[j] <= ~dq_reg[W-1][j] + W'(1);
                end
                else
                begin
                    out_reg[j] <= dq_reg[W-1][j];
                end
            end
            det_out_reg <= dv_reg[W-1];
            sing_reg    <= dz_reg[W-1];
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int j = 0; j < N_ENT; j++)
        begin
            m_tdata[j*W +: W] = out_reg[j];
        end
        m_tdata[N_ENT*W +: W] = det_out_reg;
        m_tuser[0] = sing_reg;
    end

`ifndef SYNTH
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == OTW'(0))
        else $error("singular result carries nonzero data");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the pipe has room");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && !en[NS] |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_matrix3x3_inverse.sv -----
`default_nettype none

module tb_matrix3x3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = m3inv_pkg::DEF_FRAC_BITS;
    localparam int WB = m3inv_pkg::DEF_WORD_BITS;
    localparam int NE = m3inv_pkg::N_ENT;
    localparam int LATENCY = WB + 8;
    localparam int SW = ((9*WB+7)/8)*8;
    localparam int MW = ((10*WB+7)/8)*8;
    localparam int RANDOM_WORDS = 550;

    typedef logic signed [WB-1:0] entry_t;

    typedef struct {
        entry_t inv [NE];
        entry_t det;
        logic   singular;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t pending[$];
        int errors;

        // Exact arithmetic: products of three entries fit well within 160 bits.
        static function automatic entry_t div_sat(logic signed [159:0] num,
                                                  logic signed [159:0] den);
            logic signed [159:0] q;
            logic signed [159:0] hi;
            logic signed [159:0] lo;
            hi = (160'sd1 <<< (WB-1)) - 1;
            lo = -(160'sd1 <<< (WB-1));
            q = num / den;
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q[WB-1:0];
        endfunction

        function void note_matrix(entry_t m [NE]);
            logic signed [159:0] w [NE];
            logic signed [159:0] adj [NE];
            logic signed [159:0] det;
            inverse_t r;
            for (int i = 0; i < NE; i++) w[i] = m[i];
            for (int i = 0; i < NE; i++)
                adj[i] = w[m3inv_pkg::COF_IDX[i][0]] * w[m3inv_pkg::COF_IDX[i][1]]
                       - w[m3inv_pkg::COF_IDX[i][2]] * w[m3inv_pkg::COF_IDX[i][3]];
            det = w[0]*adj[0] + w[1]*adj[3] + w[2]*adj[6];
            if (det == 0)
            begin
                for (int i = 0; i < NE; i++) r.inv[i] = '0;
                r.det = '0;
                r.singular = 1'b1;
            end
            else
            begin
                for (int i = 0; i < NE; i++)
                    r.inv[i] = div_sat(adj[i] <<< (2*FB), det);
                r.det = div_sat(det, 160'sd1 <<< (2*FB));
                r.singular = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [MW-1:0] data, logic sing);
            inverse_t e;
            entry_t got;
            if (pending.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < NE; i++)
            begin
                got = data[i*WB +: WB];
                if (got !== e.inv[i])
                begin
                    $error("inv_r%0dc%0d expected %0d actual %0d",
                           i / 3 + 1, i % 3 + 1, e.inv[i], got);
                    errors++;
                end
            end
            got = data[NE*WB +: WB];
            if (got !== e.det)
            begin
                $error("det_value expected %0d actual %0d", e.det, got);
                errors++;
            end
            if (sing !== e.singular)
            begin
                $error("singular expected %0d actual %0d", e.singular, sing);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [SW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [MW-1:0] m_tdata;
    logic [0:0] m_tuser;

    inverse_scoreboard inverses;
    bit sending_done;

    matrix3x3_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic entry_t random_entry();
        case ($urandom_range(0, 7))
            0: return entry_t'($urandom);
            1: return entry_t'($urandom_range(0, 4) - 2);
            2: return {1'b1, {(WB-1){1'b0}}};
            3: return {1'b0, {(WB-1){1'b1}}};
            default: return entry_t'($signed($urandom_range(0, 1 << (FB+3))) - (1 << (FB+2)));
        endcase
    endfunction

    // Called at a falling edge; leaves tvalid high so that words can follow
    // back to back, and drops it only when a gap comes.
    task automatic send_matrix(entry_t m [NE], bit gaps);
        int g;
        g = gaps ? gap_length() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        for (int i = 0; i < NE; i++) s_tdata[i*WB +: WB] <= m[i];
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        inverses.note_matrix(m);
        @(negedge clk);
    endtask

    task automatic send_directed();
        entry_t m [NE];
        entry_t one;
        one = entry_t'(1 << FB);
        // Identity, a mixed diagonal, diagonals that overflow, and an anti-diagonal.
        for (int k = 0; k < 6; k++)
        begin
            for (int i = 0; i < NE; i++) m[i] = '0;
            case (k)
                0:
                begin
                    m[0] = one; m[4] = one; m[8] = one;
                end
                1:
                begin
                    m[0] = one*2; m[4] = -one; m[8] = one/4;
                end
                2:
                begin
                    m[0] = 1; m[4] = 1; m[8] = 1;
                end
                3:
                begin
                    m[0] = {1'b1, {(WB-1){1'b0}}}; m[4] = m[0]; m[8] = m[0];
                end
                4:
                begin
                    m[0] = {1'b0, {(WB-1){1'b1}}}; m[4] = m[0]; m[8] = m[0];
                end
                5:
                begin
                    m[2] = one; m[4] = -one; m[6] = one;
                end
            endcase
            send_matrix(m, 1'b0);
        end
        // All zero, all extremes, and rank-deficient matrices.
        for (int i = 0; i < NE; i++) m[i] = '0;
        send_matrix(m, 1'b0);
        for (int i = 0; i < NE; i++) m[i] = {1'b1, {(WB-1){1'b0}}};
        send_matrix(m, 1'b0);
        for (int i = 0; i < NE; i++) m[i] = {1'b0, {(WB-1){1'b1}}};
        send_matrix(m, 1'b0);
        for (int i = 0; i < NE; i++) m[i] = {WB{1'b1}};
        send_matrix(m, 1'b0);
        for (int i = 0; i < NE; i++) m[i] = {WB/2{2'b10}};
        send_matrix(m, 1'b0);
        for (int i = 0; i < NE; i++) m[i] = {WB/2{2'b01}};
        send_matrix(m, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            m[i] = random_entry();
            m[i+3] = m[i];
            m[i+6] = random_entry();
        end
        send_matrix(m, 1'b0);
        // Tiny determinant with large cofactors.
        for (int i = 0; i < NE; i++) m[i] = '0;
        m[0] = 1; m[1] = one; m[4] = 1; m[8] = 1;
        send_matrix(m, 1'b0);
        m[0] = -1; m[8] = one*100;
        send_matrix(m, 1'b0);
    endtask

    initial
    begin
        entry_t m [NE];
        inverses = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_directed();
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (inverses.pending.size() != 0) @(negedge clk);
            end
            for (int i = 0; i < NE; i++) m[i] = random_entry();
            // Some singular matrices with one row a copy of another.
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++) m[6+i] = m[i];
            send_matrix(m, n % 100 >= 30);
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            inverses.check_result(m_tdata, m_tuser[0]);
    end

    initial
    begin
        wait (sending_done);
        while (inverses.pending.size() != 0) @(posedge clk);
        repeat (LATENCY * 2) @(posedge clk);
        if (inverses.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
